@@ sv/ssim_pkg.sv @@
// shared types and constants for the ssim pixel and tile sum block
package ssim_pkg;

    localparam int unsigned TilePixels = 4096;
    localparam longint SumCap = 536870911;
    localparam longint SumLimitRaw = longint'(TilePixels) * 65536;
    localparam longint SumLimitL = (SumLimitRaw > SumCap) ? SumCap : SumLimitRaw;
    localparam logic signed [29:0] SUM_LIMIT = 30'(SumLimitL);
    localparam logic [17:0] ONE_Q16 = 18'd65536;

    localparam logic CFG_C1 = 1'b0;
    localparam logic CFG_C2 = 1'b1;

    localparam logic [31:0] C1_RESET = 32'd429497;
    localparam logic [31:0] C2_RESET = 32'd3865470;

    localparam int QDEPTH = 2;

    // classified request passed from front to back
    typedef struct packed {
        logic        special;   // result known without division
        logic [17:0] sval;      // value for the special case
        logic        neg;
        logic [33:0] lnum;      // luminance numerator, unsigned
        logic [34:0] cnum;      // magnitude of contrast numerator
        logic [33:0] lden;
        logic [34:0] cden;
        logic        last;
    } t_work;

endpackage

@@ sv/ssim_pixel_and_tile_sum_top.sv @@
// top level of the ssim pixel and tile sum block
// Each request carries one pixel's blurred means and second moments; one
// result per request gives the pixel SSIM in signed Q1.16 and, on the
// request marked last of the tile, the saturated tile sum with sum_valid.
// The front forms moments in a two-stage pipeline and hands classified
// requests through a two-entry queue to the back. The back runs a
// restoring divider one quotient bit per cycle. A request passes accept,
// multiply, add, 17 divide steps, sum and output; add and divide are
// skipped when a denominator or numerator is zero, the divide ends once
// the ratio reaches one, and output holds while stalled. That divider sets
// the sustained rate. Stabilizer writes take effect on the next request.
module ssim_pixel_and_tile_sum_top import ssim_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_mean_a,
    input  logic [15:0]        i_mean_b,
    input  logic [31:0]        i_meansq_a,
    input  logic [31:0]        i_meansq_b,
    input  logic [31:0]        i_mean_prod,
    input  logic               i_last_of_tile,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [17:0] o_ssim_value,
    output logic signed [29:0] o_tile_sum,
    output logic               o_sum_valid
);
    logic [31:0] r_c1, r_c2;
    logic        f_valid, f_stall, b_valid, b_stall;
    t_work       f_work, b_work;

    // stabilizer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= C1_RESET;
            r_c2 <= C2_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_C1:  r_c1 <= i_cfg_data;
                CFG_C2:  r_c2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ssim_front u_front (
        .i_clk, .i_rst_n, .i_c1(r_c1), .i_c2(r_c2),
        .i_valid, .o_stall,
        .i_mean_a, .i_mean_b, .i_meansq_a, .i_meansq_b, .i_mean_prod,
        .i_last_of_tile,
        .o_valid(f_valid), .i_stall(f_stall), .o_work(f_work)
    );

    ssim_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_stall(f_stall), .i_data(f_work),
        .o_valid(b_valid), .i_stall(b_stall), .o_data(b_work)
    );

    ssim_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(b_valid), .o_stall(b_stall), .i_work(b_work),
        .o_valid, .i_stall, .o_ssim_value, .o_tile_sum, .o_sum_valid
    );

    // result stays in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ssim_value <= 18'sd65536 && o_ssim_value >= -18'sd65536))
        else $error("ssim out of range");

    // tile sum only shown with its flag
    a_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_sum_valid) |-> (o_tile_sum == 30'sd0))
        else $error("stray tile sum");

    // held result does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_ssim_value)))
        else $error("result dropped under stall");
endmodule

@@ sv/ssim_front.sv @@
// front: forms moments and classifies each request
module ssim_front import ssim_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_c1,
    input  logic [31:0] i_c2,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_mean_a,
    input  logic [15:0] i_mean_b,
    input  logic [31:0] i_meansq_a,
    input  logic [31:0] i_meansq_b,
    input  logic [31:0] i_mean_prod,
    input  logic        i_last_of_tile,
    output logic        o_valid,
    input  logic        i_stall,
    output t_work       o_work
);
    logic        r_s1v, n_s1v;
    logic [31:0] r_mua2, r_mub2, r_muab, r_sa, r_sb, r_sp, r_c1, r_c2;
    logic        r_last;
    logic        r_ov, n_ov;
    t_work       r_work, n_work;
    logic signed [35:0] lnum, lden, cnum, cden;
    logic adv1, adv2;

    assign adv2    = !r_ov || !i_stall;
    assign adv1    = !r_s1v || adv2;
    assign o_stall = !adv1;
    assign o_valid = r_ov;
    assign o_work  = r_work;

    // stage one: products
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_mua2 <= i_mean_a * i_mean_a;
            r_mub2 <= i_mean_b * i_mean_b;
            r_muab <= i_mean_a * i_mean_b;
            r_sa   <= i_meansq_a;
            r_sb   <= i_meansq_b;
            r_sp   <= i_mean_prod;
            r_c1   <= i_c1;
            r_c2   <= i_c2;
            r_last <= i_last_of_tile;
        end
    end

    // stage two: sums and classification
    always_comb begin
        lnum = {3'b0, r_muab, 1'b0} + {4'b0, r_c1};
        lden = {4'b0, r_mua2} + {4'b0, r_mub2} + {4'b0, r_c1};
        cnum = ({3'b0, r_sp, 1'b0} - {3'b0, r_muab, 1'b0}) + {4'b0, r_c2};
        cden = {4'b0, r_sa} - {4'b0, r_mua2} + {4'b0, r_sb} - {4'b0, r_mub2}
               + {4'b0, r_c2};
        n_work.lnum    = lnum[33:0];
        n_work.lden    = lden[33:0];
        n_work.cnum    = cnum[35] ? 35'(-cnum) : cnum[34:0];
        n_work.cden    = cden[35] ? 35'(-cden) : cden[34:0];
        n_work.neg     = cnum[35] ^ cden[35];
        n_work.last    = r_last;
        n_work.special = 1'b0;
        n_work.sval    = '0;
        // zero denominator gives one, zero numerator gives zero
        if (lden == 0 || cden == 0) begin
            n_work.special = 1'b1;
            n_work.sval    = ONE_Q16;
        end else if (lnum == 0 || cnum == 0) begin
            n_work.special = 1'b1;
        end
    end

    always_comb begin
        n_s1v = adv1 ? i_valid : r_s1v;
        n_ov  = adv2 ? r_s1v : r_ov;
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_work <= n_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_s1v <= n_s1v;
            r_ov  <= n_ov;
        end
    end
endmodule

@@ sv/ssim_queue.sv @@
// short queue between front and back
module ssim_queue import ssim_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_work i_data,
    output logic  o_valid,
    input  logic  i_stall,
    output t_work o_data
);
    t_work      r_mem [QDEPTH];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push, pop;

    assign o_stall = (r_cnt == 2'(QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_comb begin
        n_wp  = push ? !r_wp : r_wp;
        n_rp  = pop ? !r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end
endmodule

@@ sv/ssim_back.sv @@
// back: wide products, serial divide, rounding and tile sum
module ssim_back import ssim_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_work              i_work,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [17:0] o_ssim_value,
    output logic signed [29:0] o_tile_sum,
    output logic               o_sum_valid
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  r_st, n_st;
    t_work       r_w;
    // partial products of the 34-bit factor with the 17/18-bit halves of the other
    logic [50:0] r_nl_lo, r_dl_lo;
    logic [51:0] r_nl_hi, r_dl_hi;
    logic [69:0] r_num, r_den, r_rem, n_rem;
    logic [16:0] r_acc;
    logic [4:0]  r_cnt;
    logic signed [17:0] n_q;
    logic signed [29:0] r_run, r_osum;
    logic signed [17:0] r_oval;
    logic        r_osv;
    logic [70:0] shl, dif;
    logic signed [31:0] sum;
    logic signed [29:0] clamped;

    assign o_stall      = (r_st != ST_IDLE);
    assign o_valid      = (r_st == ST_OUT);
    assign o_ssim_value = r_oval;
    assign o_tile_sum   = r_osum;
    assign o_sum_valid  = r_osv;

    // one restoring divide step
    always_comb begin
        shl   = {r_rem, 1'b0};
        dif   = shl - {1'b0, r_den};
        n_rem = dif[70] ? shl[69:0] : dif[69:0];
    end

    // rounded, signed quotient
    always_comb begin
        logic [17:0] mag;
        mag = 18'(({1'b0, r_acc} + 18'd1) >> 1);
        if (r_w.special) begin
            n_q = signed'(r_w.sval);
        end else if (r_num >= r_den) begin
            n_q = r_w.neg ? -signed'(ONE_Q16) : signed'(ONE_Q16);
        end else begin
            n_q = r_w.neg ? -signed'(mag) : signed'(mag);
        end
    end

    // saturating tile sum
    always_comb begin
        sum = 32'(r_run) + 32'(n_q);
        if (sum > 32'(SUM_LIMIT)) begin
            clamped = SUM_LIMIT;
        end else if (sum < -32'(SUM_LIMIT)) begin
            clamped = -SUM_LIMIT;
        end else begin
            clamped = sum[29:0];
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (i_valid) n_st = ST_MUL;
            ST_MUL:  n_st = r_w.special ? ST_SUM : ST_ADD;
            ST_ADD:  n_st = ST_DIV;
            ST_DIV:  if (r_cnt == 5'd16 || r_num >= r_den) n_st = ST_SUM;
            ST_SUM:  n_st = ST_OUT;
            ST_OUT:  if (!i_stall) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_w <= i_work;
            end
            ST_MUL: begin
                // a*b = a*bl + (a*bh << 17), each at most 34x18
                r_nl_lo <= {17'b0, r_w.lnum} * {34'b0, r_w.cnum[16:0]};
                r_nl_hi <= {18'b0, r_w.lnum} * {34'b0, r_w.cnum[34:17]};
                r_dl_lo <= {17'b0, r_w.lden} * {34'b0, r_w.cden[16:0]};
                r_dl_hi <= {18'b0, r_w.lden} * {34'b0, r_w.cden[34:17]};
            end
            ST_ADD: begin
                r_num <= 70'(r_nl_lo) + (70'(r_nl_hi) << 17);
                r_den <= 70'(r_dl_lo) + (70'(r_dl_hi) << 17);
                r_rem <= 70'(r_nl_lo) + (70'(r_nl_hi) << 17);
                r_acc <= '0;
                r_cnt <= '0;
            end
            ST_DIV: begin
                r_rem <= n_rem;
                r_acc <= {r_acc[15:0], !dif[70]};
                r_cnt <= r_cnt + 5'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_SUM) begin
            r_oval <= n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_run  <= '0;
            r_osum <= '0;
            r_osv  <= 1'b0;
        end else begin
            r_st <= n_st;
            // result and running sum settle before the result is shown
            if (r_st == ST_SUM) begin
                if (r_w.last) begin
                    r_run  <= '0;
                    r_osv  <= 1'b1;
                    r_osum <= clamped;
                end else begin
                    r_run  <= clamped;
                    r_osv  <= 1'b0;
                    r_osum <= '0;
                end
            end
        end
    end
endmodule

@@ tb/tb_ssim_pixel_and_tile_sum_top.sv @@
// testbench for the ssim pixel and tile sum block: queued driver, checking monitor
module tb_ssim_pixel_and_tile_sum_top;
    import ssim_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [15:0] ma;
        logic [15:0] mb;
        logic [31:0] sa;
        logic [31:0] sb;
        logic [31:0] sp;
        logic        last;
    } pixel_t;

    typedef struct {
        logic signed [17:0] ssim;
        logic signed [29:0] sum;
        logic               sum_ok;
    } pixel_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = CFG_C1;
    logic [31:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [15:0]        i_mean_a = '0;
    logic [15:0]        i_mean_b = '0;
    logic [31:0]        i_meansq_a = '0;
    logic [31:0]        i_meansq_b = '0;
    logic [31:0]        i_mean_prod = '0;
    logic               i_last_of_tile = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [17:0] o_ssim_value;
    logic signed [29:0] o_tile_sum;
    logic               o_sum_valid;

    pixel_t        pending_px[$];
    pixel_result_t expected_px[$];
    pixel_t        cur_px;
    logic          req_taken = 1'b0;
    logic [31:0]   c1_model = C1_RESET;
    logic [31:0]   c2_model = C2_RESET;
    longint        tile_acc = 0;
    int            snd_idle_pct = 0;
    int            rcv_stall_pct = 0;
    logic          hold_req = 1'b0;
    int            hold_left = 0;
    int            errors = 0;
    int            quiet_cycles = 0;

    ssim_pixel_and_tile_sum_top dut (.*);

    always #6 i_clk = ~i_clk;

    // per-pixel ssim, exact moments and rounded 17-bit restoring quotient
    function automatic longint pixel_ssim_q16(pixel_t p);
        longint      mua2, mub2, muab, lnum, lden, cnum, cden, q;
        logic [127:0] num, den, quo;
        logic        neg;
        mua2 = longint'(p.ma) * longint'(p.ma);
        mub2 = longint'(p.mb) * longint'(p.mb);
        muab = longint'(p.ma) * longint'(p.mb);
        lnum = 2 * muab + longint'(c1_model);
        lden = mua2 + mub2 + longint'(c1_model);
        cnum = 2 * (longint'(p.sp) - muab) + longint'(c2_model);
        cden = (longint'(p.sa) - mua2) + (longint'(p.sb) - mub2) + longint'(c2_model);
        if (lden == 0 || cden == 0) return 65536;
        if (lnum == 0 || cnum == 0) return 0;
        neg = (cnum < 0) != (cden < 0);
        num = 128'(unsigned'(lnum)) * 128'(unsigned'(cnum < 0 ? -cnum : cnum));
        den = 128'(unsigned'(lden)) * 128'(unsigned'(cden < 0 ? -cden : cden));
        if (num >= den) begin
            q = 65536;
        end else begin
            quo = (num << 17) / den;
            q = longint'((quo + 1) >> 1);
        end
        return neg ? -q : q;
    endfunction

    // request side: predict on acceptance, watchdog on idle cycles
    always @(posedge i_clk) begin
        pixel_result_t r;
        longint        s;
        longint        acc;
        if (i_rst_n && i_valid && !o_stall) begin
            s = pixel_ssim_q16(cur_px);
            acc = tile_acc + s;
            if (acc > longint'(SUM_LIMIT)) acc = longint'(SUM_LIMIT);
            if (acc < -longint'(SUM_LIMIT)) acc = -longint'(SUM_LIMIT);
            r.ssim = 18'(s);
            r.sum_ok = cur_px.last;
            r.sum = cur_px.last ? 30'(acc) : '0;
            tile_acc = cur_px.last ? 0 : acc;
            expected_px.push_back(r);
            req_taken = 1'b1;
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("ssim_pixel_and_tile_sum_top: mismatch");
            $finish;
        end
    end

    // driver: hold request while stalled, else maybe launch the next one
    always @(negedge i_clk) begin
        logic nv;
        nv = i_valid && !req_taken;
        req_taken = 1'b0;
        if (!nv && pending_px.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
            cur_px = pending_px.pop_front();
            nv = 1'b1;
            i_mean_a <= cur_px.ma;
            i_mean_b <= cur_px.mb;
            i_meansq_a <= cur_px.sa;
            i_meansq_b <= cur_px.sb;
            i_mean_prod <= cur_px.sp;
            i_last_of_tile <= cur_px.last;
        end
        i_valid <= nv;
    end

    // receiver stall: long hold-off on demand, otherwise random
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge i_clk) begin
        pixel_result_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_px.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result ssim=%0d", o_ssim_value);
            end else begin
                e = expected_px.pop_front();
                if (o_ssim_value !== e.ssim || o_tile_sum !== e.sum
                        || o_sum_valid !== e.sum_ok) begin
                    errors++;
                    if (errors <= 10)
                        $display("exp ssim=%0d sum=%0d sv=%0b got ssim=%0d sum=%0d sv=%0b",
                                 e.ssim, e.sum, e.sum_ok,
                                 o_ssim_value, o_tile_sum, o_sum_valid);
                end
            end
        end
    end

    task automatic write_cfg(logic idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_C1) c1_model = val;
        else c2_model = val;
    endtask

    task automatic set_consts(logic [31:0] c1, logic [31:0] c2);
        write_cfg(CFG_C1, c1);
        write_cfg(CFG_C2, c2);
    endtask

    // wait for every request and result, then let the divider settle
    task automatic drain();
        while (pending_px.size() > 0 || i_valid || expected_px.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_px(logic [15:0] ma, logic [15:0] mb, logic [31:0] sa,
                          logic [31:0] sb, logic [31:0] sp, logic last);
        pixel_t p;
        p.ma = ma; p.mb = mb; p.sa = sa; p.sb = sb; p.sp = sp; p.last = last;
        pending_px.push_back(p);
    endtask

    function automatic logic [31:0] clamp32(longint v);
        if (v < 0) return '0;
        if (v > 64'hFFFF_FFFF) return '1;
        return 32'(v);
    endfunction

    // edge cases: zeros, full scale, negative variance, zero numerators
    task automatic add_directed();
        add_px(16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        add_px(16'hFFFF, 16'hFFFF, '1, '1, '1, 1'b0);
        add_px(16'hFFFF, 16'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        add_px(16'h0, 16'hFFFF, '1, 32'h0, '1, 1'b1);
        add_px(16'h8000, 16'h8000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 1'b0);
        add_px(16'hFFFF, 16'hFFFF, 32'h0, 32'h0, 32'h0, 1'b0);
        add_px(16'h1234, 16'h4321, 32'h0, '1, 32'h0, 1'b0);
        add_px(16'h0, 16'h0, 32'h0, 32'h0, 32'h1, 1'b0);
        add_px(16'h0001, 16'h0001, 32'h1, 32'h1, 32'h1, 1'b1);
        add_px(16'hFFFF, 16'h0001, 32'hFFFE_0001, 32'h1, 32'h0, 1'b1);
        add_px(16'h00FF, 16'hFF00, '1, '1, 32'h0, 1'b0);
        add_px(16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 1'b1);
    endtask

    // random pixels: mostly consistent moments, some raw noise
    task automatic add_random(int n);
        logic [15:0] ma, mb;
        longint      va, vb, cv;
        int          kind;
        repeat (n) begin
            ma = 16'($urandom);
            mb = ($urandom_range(3) == 0) ? ma : 16'($urandom);
            kind = $urandom_range(9);
            if (kind < 2) begin
                add_px(ma, mb, $urandom, $urandom, $urandom, $urandom_range(15) == 0);
            end else begin
                va = longint'($urandom_range(0, 32'h00FF_FFFF)) >> $urandom_range(24);
                vb = (kind == 2) ? va
                     : longint'($urandom_range(0, 32'h00FF_FFFF)) >> $urandom_range(24);
                cv = longint'($urandom_range(0, 32'h00FF_FFFF)) >> $urandom_range(24);
                if ($urandom_range(1)) cv = -cv;
                add_px(ma, mb, clamp32(longint'(ma) * ma + va),
                       clamp32(longint'(mb) * mb + vb),
                       clamp32(longint'(ma) * mb + cv), $urandom_range(15) == 0);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass under reset constants, all zero and full scale
        add_directed();
        drain();
        set_consts(32'h0, 32'h0);
        add_directed();
        drain();
        set_consts('1, '1);
        add_directed();
        drain();

        // random phases with different idling, stalls and constants
        set_consts(C1_RESET, C2_RESET);
        add_random(340);
        drain();
        set_consts($urandom, $urandom);
        snd_idle_pct = 56;
        add_random(330);
        drain();
        set_consts($urandom_range(0, 32'h00FF_FFFF), $urandom_range(0, 32'h00FF_FFFF));
        snd_idle_pct = 0;
        rcv_stall_pct = 56;
        add_random(330);
        drain();
        set_consts(C1_RESET, C2_RESET);
        snd_idle_pct = 15;
        rcv_stall_pct = 15;
        hold_req = 1'b1;
        add_random(330);
        drain();

        if (errors == 0) begin
            $display("ssim_pixel_and_tile_sum_top: match");
        end else begin
            $display("ssim_pixel_and_tile_sum_top: mismatch");
        end
        $finish;
    end

endmodule
